@@ hdl/glb_pkg.sv @@
// glb_pkg: shared types, codes and constants of the glyph bitmap locator
// used by glb_seg_table, glb_core and glyph_bitmap_locator; no dependencies

package glb_pkg;

    // default sizes of the segment table and the sorted code map
    localparam int MAX_SEGMENTS_DEF = 4;
    localparam int MAP_DEPTH_DEF    = 8192;

    localparam int CODE_W    = 21;
    localparam int MAP_W     = 16;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 16;
    localparam int CWIDTH_W  = 8;
    localparam int ENTRIES_W = 14;
    localparam int STATUS_W  = 3;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_LOOKUP    = 2'd0;
    localparam logic [1:0] CMD_SEG_WRITE = 2'd1;
    localparam logic [1:0] CMD_MAP_WRITE = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_MODE  = 3'd1;
    localparam logic [2:0] ST_KIND1 = 3'd2;
    localparam logic [2:0] ST_MISS  = 3'd3;
    localparam logic [2:0] ST_KIND  = 3'd4;
    localparam logic [2:0] ST_NONE  = 3'd5;

    // segment map kinds
    localparam logic [7:0] KIND_OWN_MAP = 8'h01;
    localparam logic [7:0] KIND_ASCII   = 8'h02;
    localparam logic [7:0] KIND_SORTED  = 8'h03;

    localparam logic [7:0] MODE_MEMORY = 8'h01;

    // kind 2 glyphs start at the space character
    localparam logic [31:0] ASCII_FIRST = 32'd32;
    // kind 3 stride is line_height squared bits, rounded up to whole bytes
    localparam logic [16:0] BYTE_ROUND  = 17'd7;
    localparam int          BYTE_SHIFT  = 3;

    // configuration register indexes
    localparam logic [1:0] REG_SEGMENT_COUNT = 2'd0;
    localparam logic [1:0] REG_ACCESS_MODE   = 2'd1;
    localparam logic [1:0] REG_LINE_HEIGHT   = 2'd2;

    localparam logic [2:0] SEGMENT_COUNT_RST = 3'd0;
    localparam logic [7:0] ACCESS_MODE_RST   = 8'd1;
    localparam logic [7:0] LINE_HEIGHT_RST   = 8'd16;

    typedef struct packed {
        logic [CODE_W-1:0]    lower;
        logic [CODE_W-1:0]    upper;
        logic [7:0]           kind;
        logic [LEN_W-1:0]     glyph_bytes;
        logic [CWIDTH_W-1:0]  char_width;
        logic [ADDR_W-1:0]    base;
        logic [ENTRIES_W-1:0] entries;
    } seg_entry_t;

    typedef struct packed {
        logic [2:0] segment_count;
        logic [7:0] access_mode;
        logic [7:0] line_height;
    } cfg_t;

endpackage

@@ hdl/glb_ram.sv @@
// glb_ram: generic single write port, single read port ram with registered read
// no dependencies

module glb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/glb_seg_table.sv @@
// glb_seg_table: code-point segment table, written one entry at a time,
// read at the scan index; depends on glb_pkg

module glb_seg_table #(
    parameter int MAX_SEGMENTS = glb_pkg::MAX_SEGMENTS_DEF,
    parameter int SEG_IDX_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
    input  logic                clk,
    input  logic                we,
    input  logic [1:0]          windex,
    input  glb_pkg::seg_entry_t wentry,
    input  logic [SEG_IDX_W-1:0] rindex,
    output glb_pkg::seg_entry_t rentry
);

    glb_pkg::seg_entry_t table_reg [MAX_SEGMENTS];
    logic [31:0]         windex_wide;

    assign windex_wide = 32'(windex);

    // writes beyond the table are dropped
    always_ff @(posedge clk)
    begin
        if (we && (windex_wide < 32'(MAX_SEGMENTS)))
        begin
            table_reg[windex_wide[SEG_IDX_W-1:0]] <= wentry;
        end
    end

    assign rentry = table_reg[rindex];

endmodule

@@ hdl/glb_core.sv @@
// glb_core: lookup sequencer around one shared 32x16 multiplier and map compare
// depends on glb_pkg; reads glb_seg_table and the map glb_ram

module glb_core #(
    parameter int MAX_SEGMENTS = glb_pkg::MAX_SEGMENTS_DEF,
    parameter int MAP_DEPTH    = glb_pkg::MAP_DEPTH_DEF,
    parameter int SEG_IDX_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    parameter int MAP_AW       = $clog2(MAP_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  glb_pkg::cfg_t         cfg,
    input  logic                  start,
    input  logic [1:0]            command,
    input  logic [glb_pkg::CODE_W-1:0] letter,
    output logic                  in_ready,
    output logic [SEG_IDX_W-1:0]  seg_rindex,
    input  glb_pkg::seg_entry_t   seg_rentry,
    output logic [MAP_AW-1:0]     map_raddr,
    input  logic [glb_pkg::MAP_W-1:0] map_rdata,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [glb_pkg::STATUS_W-1:0] res_status,
    output logic [glb_pkg::ADDR_W-1:0]   res_address,
    output logic [glb_pkg::LEN_W-1:0]    res_length,
    output logic [glb_pkg::CWIDTH_W-1:0] res_width
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [3:0] {
        IDLE,
        SCAN,
        MUL_STRIDE,
        STRIDE,
        SEARCH,
        COMPARE,
        MUL_ADDR,
        ADD,
        RESULT
    } state_t;

    state_t                          state_reg;
    logic [glb_pkg::CODE_W-1:0]      letter_reg;
    logic [CNT_W-1:0]                idx_reg;
    logic [CNT_W-1:0]                limit_reg;
    logic [MAP_AW:0]                 lo_reg;
    logic [MAP_AW:0]                 hie_reg;
    logic [MAP_AW-1:0]               mid_reg;
    logic [31:0]                     op_a_reg;
    logic [15:0]                     op_b_reg;
    logic [31:0]                     prod_reg;
    logic [glb_pkg::ADDR_W-1:0]      base_reg;
    logic [glb_pkg::STATUS_W-1:0]    status_reg;
    logic [glb_pkg::ADDR_W-1:0]      addr_reg;
    logic [glb_pkg::LEN_W-1:0]       len_reg;
    logic [glb_pkg::CWIDTH_W-1:0]    cw_reg;
    logic                            out_valid_reg;
    logic [glb_pkg::STATUS_W-1:0]    out_status_reg;
    logic [glb_pkg::ADDR_W-1:0]      out_addr_reg;
    logic [glb_pkg::LEN_W-1:0]       out_len_reg;
    logic [glb_pkg::CWIDTH_W-1:0]    out_cw_reg;

    logic [47:0]       mul_full;
    logic [MAP_AW+1:0] mid_sum;
    logic [MAP_AW-1:0] mid_w;
    logic [CNT_W-1:0]  seg_limit;
    logic [MAP_AW:0]   entries_lim;
    logic              in_range;
    logic [15:0]       key;

    // shared multiplier, address arithmetic wraps at 32 bits
    assign mul_full = op_a_reg * op_b_reg;

    // probe point of the inclusive range [lo, hie-1]
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hie_reg} - (MAP_AW + 2)'(1);
    assign mid_w   = mid_sum[MAP_AW:1];

    assign seg_limit = (32'(cfg.segment_count) > 32'(MAX_SEGMENTS))
                       ? CNT_W'(MAX_SEGMENTS) : CNT_W'(cfg.segment_count);
    assign entries_lim = (32'(seg_rentry.entries) > 32'(MAP_DEPTH))
                         ? (MAP_AW + 1)'(MAP_DEPTH) : (MAP_AW + 1)'(seg_rentry.entries);
    assign in_range = (seg_rentry.lower <= letter_reg) && (seg_rentry.upper >= letter_reg);
    assign key      = letter_reg[15:0];

    assign seg_rindex = idx_reg[SEG_IDX_W-1:0];
    assign map_raddr  = mid_w;
    assign in_ready   = (state_reg == IDLE);

    assign res_valid   = out_valid_reg;
    assign res_status  = out_status_reg;
    assign res_address = out_addr_reg;
    assign res_length  = out_len_reg;
    assign res_width   = out_cw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            letter_reg     <= '0;
            idx_reg        <= '0;
            limit_reg      <= '0;
            lo_reg         <= '0;
            hie_reg        <= '0;
            mid_reg        <= '0;
            op_a_reg       <= '0;
            op_b_reg       <= '0;
            prod_reg       <= '0;
            base_reg       <= '0;
            status_reg     <= glb_pkg::ST_OK;
            addr_reg       <= '0;
            len_reg        <= '0;
            cw_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= glb_pkg::ST_OK;
            out_addr_reg   <= '0;
            out_len_reg    <= '0;
            out_cw_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && res_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        letter_reg <= letter;
                        idx_reg    <= '0;
                        limit_reg  <= seg_limit;
                        status_reg <= glb_pkg::ST_OK;
                        addr_reg   <= '0;
                        len_reg    <= '0;
                        cw_reg     <= '0;
                        state_reg  <= RESULT;
                        if (command == glb_pkg::CMD_LOOKUP)
                        begin
                            if (cfg.access_mode != glb_pkg::MODE_MEMORY)
                            begin
                                status_reg <= glb_pkg::ST_MODE;
                            end
                            else if (seg_limit == '0)
                            begin
                                status_reg <= glb_pkg::ST_NONE;
                            end
                            else
                            begin
                                state_reg <= SCAN;
                            end
                        end
                    end
                end

                SCAN:
                begin
                    if (in_range)
                    begin
                        base_reg <= seg_rentry.base;
                        case (seg_rentry.kind)
                            glb_pkg::KIND_OWN_MAP:
                            begin
                                status_reg <= glb_pkg::ST_KIND1;
                                state_reg  <= RESULT;
                            end
                            glb_pkg::KIND_ASCII:
                            begin
                                op_a_reg  <= 32'(letter_reg) - glb_pkg::ASCII_FIRST;
                                op_b_reg  <= seg_rentry.glyph_bytes;
                                len_reg   <= seg_rentry.glyph_bytes;
                                cw_reg    <= seg_rentry.char_width;
                                state_reg <= MUL_ADDR;
                            end
                            glb_pkg::KIND_SORTED:
                            begin
                                op_a_reg  <= 32'(cfg.line_height);
                                op_b_reg  <= 16'(cfg.line_height);
                                lo_reg    <= '0;
                                hie_reg   <= entries_lim;
                                state_reg <= MUL_STRIDE;
                            end
                            default:
                            begin
                                status_reg <= glb_pkg::ST_KIND;
                                state_reg  <= RESULT;
                            end
                        endcase
                    end
                    else if (idx_reg + CNT_W'(1) == limit_reg)
                    begin
                        status_reg <= glb_pkg::ST_NONE;
                        state_reg  <= RESULT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end

                MUL_STRIDE:
                begin
                    prod_reg  <= mul_full[31:0];
                    state_reg <= STRIDE;
                end

                STRIDE:
                begin
                    // op_b keeps the glyph stride for the final multiply
                    op_b_reg  <= 16'((prod_reg[16:0] + glb_pkg::BYTE_ROUND)
                                     >> glb_pkg::BYTE_SHIFT);
                    state_reg <= SEARCH;
                end

                SEARCH:
                begin
                    if (lo_reg < hie_reg)
                    begin
                        mid_reg   <= mid_w;
                        state_reg <= COMPARE;
                    end
                    else
                    begin
                        status_reg <= glb_pkg::ST_MISS;
                        state_reg  <= RESULT;
                    end
                end

                COMPARE:
                begin
                    if (key < map_rdata)
                    begin
                        hie_reg   <= {1'b0, mid_reg};
                        state_reg <= SEARCH;
                    end
                    else if (key > map_rdata)
                    begin
                        lo_reg    <= {1'b0, mid_reg} + (MAP_AW + 1)'(1);
                        state_reg <= SEARCH;
                    end
                    else
                    begin
                        op_a_reg  <= 32'(mid_reg);
                        len_reg   <= seg_rentry.glyph_bytes;
                        cw_reg    <= seg_rentry.char_width;
                        state_reg <= MUL_ADDR;
                    end
                end

                MUL_ADDR:
                begin
                    prod_reg  <= mul_full[31:0];
                    state_reg <= ADD;
                end

                ADD:
                begin
                    addr_reg  <= base_reg + prod_reg;
                    state_reg <= RESULT;
                end

                RESULT:
                begin
                    if (!out_valid_reg || res_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_addr_reg   <= addr_reg;
                        out_len_reg    <= len_reg;
                        out_cw_reg     <= cw_reg;
                        state_reg      <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/glyph_bitmap_locator.sv @@
// glyph_bitmap_locator: top level with configuration registers, segment table,
// code map ram and lookup core; depends on glb_pkg, glb_ram, glb_seg_table, glb_core
//
// usage:
//   s_* carries one command word: tuser selects lookup, segment write or map
//   word write, tdata holds the letter and the table write fields.
//   m_* returns exactly one result word for every command word; write and
//   unused commands answer with every field zero.
//   cfg_* writes segment_count (index 0), access_mode (1) or line_height (2);
//   always ready; the user must write it only with no command in flight (unenforced).
// sequencing:
//   s_tready is high only while the sequencer is idle. a write command goes
//   straight to the result state. a lookup scans the segments in turn (up to
//   segment_count); kind 2 then does the multiply and add, kind 3 first forms
//   the glyph stride and then runs a binary search, one map ram read and one
//   compare per probe (about 14 probes for 8192 words), before the multiply and add.
// reset: registers return to their reset values, tables keep old contents.
// stall: a finished result sits in the output register; the next command is
//   taken meanwhile and its result waits until m_tready frees that register.

module glyph_bitmap_locator #(
    parameter int MAX_SEGMENTS = glb_pkg::MAX_SEGMENTS_DEF,
    parameter int MAP_DEPTH    = glb_pkg::MAP_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // command word
    input  logic         s_tvalid,
    output logic         s_tready,
    // letter, seg_index, seg_min, seg_max, seg_kind, seg_glyph_bytes,
    // seg_char_width, seg_base, seg_entries, map_index, map_word
    input  logic [175:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    // result word
    output logic         m_tvalid,
    input  logic         m_tready,
    // glyph_address, glyph_length, char_width
    output logic [55:0]  m_tdata,
    // status
    output logic [2:0]   m_tuser,
    // configuration write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    localparam int SEG_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    glb_pkg::cfg_t       cfg_reg;
    glb_pkg::seg_entry_t seg_wentry;
    glb_pkg::seg_entry_t seg_rentry;
    logic [SEG_IDX_W-1:0] seg_rindex;
    logic                accept;
    logic [1:0]          command;
    logic [20:0]         letter;
    logic [1:0]          seg_index;
    logic [12:0]         map_index;
    logic [15:0]         map_word;
    logic [31:0]         map_index_wide;
    logic                seg_we;
    logic                map_we;
    logic [MAP_AW-1:0]   map_raddr;
    logic [15:0]         map_rdata;
    logic [2:0]          res_status;
    logic [31:0]         res_address;
    logic [15:0]         res_length;
    logic [7:0]          res_width;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.segment_count <= glb_pkg::SEGMENT_COUNT_RST;
            cfg_reg.access_mode   <= glb_pkg::ACCESS_MODE_RST;
            cfg_reg.line_height   <= glb_pkg::LINE_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                glb_pkg::REG_SEGMENT_COUNT: cfg_reg.segment_count <= cfg_data[2:0];
                glb_pkg::REG_ACCESS_MODE:   cfg_reg.access_mode   <= cfg_data;
                glb_pkg::REG_LINE_HEIGHT:   cfg_reg.line_height   <= cfg_data;
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // unpack the command word
    assign command                = s_tuser;
    assign letter                 = s_tdata[20:0];
    assign seg_index              = s_tdata[22:21];
    assign seg_wentry.lower       = s_tdata[43:23];
    assign seg_wentry.upper       = s_tdata[64:44];
    assign seg_wentry.kind        = s_tdata[72:65];
    assign seg_wentry.glyph_bytes = s_tdata[88:73];
    assign seg_wentry.char_width  = s_tdata[96:89];
    assign seg_wentry.base        = s_tdata[128:97];
    assign seg_wentry.entries     = s_tdata[142:129];
    assign map_index              = s_tdata[155:143];
    assign map_word               = s_tdata[171:156];

    assign accept         = s_tvalid && s_tready;
    assign seg_we         = accept && (command == glb_pkg::CMD_SEG_WRITE);
    assign map_index_wide = 32'(map_index);
    assign map_we         = accept && (command == glb_pkg::CMD_MAP_WRITE)
                            && (map_index_wide < 32'(MAP_DEPTH));

    glb_seg_table #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SEG_IDX_W    (SEG_IDX_W)
    ) u_seg_table (
        .clk    (clk),
        .we     (seg_we),
        .windex (seg_index),
        .wentry (seg_wentry),
        .rindex (seg_rindex),
        .rentry (seg_rentry)
    );

    glb_ram #(
        .WIDTH (glb_pkg::MAP_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_index_wide[MAP_AW-1:0]),
        .wdata (map_word),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    glb_core #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAP_DEPTH    (MAP_DEPTH),
        .SEG_IDX_W    (SEG_IDX_W),
        .MAP_AW       (MAP_AW)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .start       (accept),
        .command     (command),
        .letter      (letter),
        .in_ready    (s_tready),
        .seg_rindex  (seg_rindex),
        .seg_rentry  (seg_rentry),
        .map_raddr   (map_raddr),
        .map_rdata   (map_rdata),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_status  (res_status),
        .res_address (res_address),
        .res_length  (res_length),
        .res_width   (res_width)
    );

    assign m_tdata = {res_width, res_length, res_address};
    assign m_tuser = res_status;

endmodule
